FILE: rtl/pbk_pkg.sv
// ----------------------------------------------------------------------------
// PBKDF2 engine package
// Shared types, codes, constants and the SHA-256 round constant table.
// ----------------------------------------------------------------------------
package pbk_pkg;

  localparam int HASH_BYTES  = 32;
  localparam int BLOCK_BYTES = 64;
  localparam int KEY_MAX     = 64;

  localparam logic [1:0] CMD_PASSWORD = 2'd0;
  localparam logic [1:0] CMD_SALT     = 2'd1;
  localparam logic [1:0] CMD_START    = 2'd2;

  localparam logic       REG_ITER  = 1'b0;
  localparam logic       REG_DLEN  = 1'b1;

  localparam logic [31:0] ITER_RESET = 32'd120000;
  localparam logic [6:0]  DLEN_RESET = 7'd32;

  localparam logic [7:0] IPAD_BYTE = 8'h36;
  localparam logic [7:0] OPAD_BYTE = 8'h5c;
  localparam logic [7:0] PAD_MARK  = 8'h80;

  localparam logic [255:0] SHA_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] key_byte;
    logic       last_byte;
    logic       overflow;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MSG_INIT, ST_FEED, ST_SETTLE, ST_COMP_GO, ST_COMP_WAIT,
    ST_MSG_DONE, ST_STORE, ST_OUT_RD, ST_OUT_LD, ST_OUT_HOLD
  } state_t;

  typedef enum logic [2:0] {
    MODE_KEYHASH, MODE_IPAD, MODE_OPAD, MODE_INNER1, MODE_INNERJ, MODE_OUTER
  } mode_t;

  typedef enum logic [1:0] {SRC_CONST, SRC_PWD, SRC_SALT, SRC_MSG} src_t;
  typedef enum logic [1:0] {HSEL_IV, HSEL_IPAD, HSEL_OPAD} hsel_t;
  typedef enum logic [2:0] {SAVE_NONE, SAVE_MSG, SAVE_IPAD, SAVE_OPAD, SAVE_OUTER} save_t;

  typedef struct packed {
    logic       byte_vld;
    src_t       src;
    logic [7:0] const_byte;
    logic [7:0] xor_byte;
    logic [4:0] msg_idx;
    logic       h_init;
    hsel_t      h_sel;
    logic       comp_go;
    save_t      save;
    logic       acc_first;
    logic       dk_we;
    logic [5:0] dk_idx;
    logic       out_load;
    logic       out_last;
    logic       out_ovf;
  } ctl_cmd_t;

  typedef struct packed {
    logic comp_done;
  } dp_status_t;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    case (t)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

FILE: rtl/pbk_stream_if.sv
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// Carries one payload of the given type per transaction.
// ----------------------------------------------------------------------------
interface pbk_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/pbk_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pbk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/pbk_datapath.sv
// ----------------------------------------------------------------------------
// PBKDF2 datapath
// Byte stores, message window, SHA-256 round unit and the HMAC state registers.
// ----------------------------------------------------------------------------
module pbk_datapath import pbk_pkg::*; #(
  parameter int PASSWORD_MAX = 128,
  parameter int SALT_MAX     = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ctl_cmd_t                        cmd,
  output dp_status_t                      status,
  input  logic [7:0]                      in_byte,
  input  logic                            pwd_we,
  input  logic [$clog2(PASSWORD_MAX)-1:0] pwd_addr,
  input  logic                            salt_we,
  input  logic [$clog2(SALT_MAX)-1:0]     salt_addr,
  output out_item_t                       out_item
);
  logic [7:0]       pwd_rdata, salt_rdata, dk_rdata, dk_wdata;
  logic             byte_vld_r;
  src_t             src_r;
  logic [7:0]       const_r, xor_r, feed_byte;
  logic [4:0]       idx_r;
  logic [511:0]     win_r;
  logic [0:7][31:0] h_r, v_r, v_nxt;
  logic [255:0]     ipad_r, opad_r, msg_r, acc_r, h_sel_val;
  logic [5:0]       rnd_r;
  logic             busy_r, fin_r;
  logic [31:0]      w0, w1, w9, w14, wnew, s0, s1, t1, t2, ch, maj;
  out_item_t        out_r;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  pbk_ram #(.WIDTH(8), .DEPTH(PASSWORD_MAX)) u_pwd_ram (
    .clk(clk), .we(pwd_we), .waddr(pwd_addr), .wdata(in_byte),
    .raddr(pwd_addr), .rdata(pwd_rdata)
  );

  pbk_ram #(.WIDTH(8), .DEPTH(SALT_MAX)) u_salt_ram (
    .clk(clk), .we(salt_we), .waddr(salt_addr), .wdata(in_byte),
    .raddr(salt_addr), .rdata(salt_rdata)
  );

  assign dk_wdata = acc_r[{~cmd.dk_idx[4:0], 3'b000} +: 8];

  pbk_ram #(.WIDTH(8), .DEPTH(KEY_MAX)) u_dk_ram (
    .clk(clk), .we(cmd.dk_we), .waddr(cmd.dk_idx), .wdata(dk_wdata),
    .raddr(cmd.dk_idx), .rdata(dk_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
      busy_r     <= 1'b0;
      fin_r      <= 1'b0;
    end else begin
      byte_vld_r <= cmd.byte_vld;
      fin_r      <= busy_r && (rnd_r == 6'd63);
      if (cmd.comp_go) begin
        busy_r <= 1'b1;
      end else if (busy_r && rnd_r == 6'd63) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    src_r   <= cmd.src;
    const_r <= cmd.const_byte;
    xor_r   <= cmd.xor_byte;
    idx_r   <= cmd.msg_idx;
  end

  always_comb begin
    case (src_r)
      SRC_PWD:  feed_byte = pwd_rdata ^ xor_r;
      SRC_SALT: feed_byte = salt_rdata ^ xor_r;
      SRC_MSG:  feed_byte = msg_r[{~idx_r, 3'b000} +: 8] ^ xor_r;
      default:  feed_byte = const_r ^ xor_r;
    endcase
  end

  assign w0  = win_r[511:480];
  assign w1  = win_r[479:448];
  assign w9  = win_r[223:192];
  assign w14 = win_r[63:32];
  assign s0  = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
  assign s1  = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
  assign wnew = w0 + s0 + w9 + s1;

  always_comb begin
    ch  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    maj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1  = v_r[7] + (rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25)) + ch
          + round_k(rnd_r) + w0;
    t2  = (rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22)) + maj;
    v_nxt    = v_r;
    v_nxt[7] = v_r[6];
    v_nxt[6] = v_r[5];
    v_nxt[5] = v_r[4];
    v_nxt[4] = v_r[3] + t1;
    v_nxt[3] = v_r[2];
    v_nxt[2] = v_r[1];
    v_nxt[1] = v_r[0];
    v_nxt[0] = t1 + t2;
  end

  always_comb begin
    case (cmd.h_sel)
      HSEL_IPAD: h_sel_val = ipad_r;
      HSEL_OPAD: h_sel_val = opad_r;
      default:   h_sel_val = SHA_IV;
    endcase
  end

  always_ff @(posedge clk) begin
    if (byte_vld_r) begin
      win_r <= {win_r[503:0], feed_byte};
    end else if (busy_r) begin
      win_r <= {win_r[479:0], wnew};
    end
    if (cmd.comp_go) begin
      v_r   <= h_r;
      rnd_r <= 6'd0;
    end else if (busy_r) begin
      v_r   <= v_nxt;
      rnd_r <= rnd_r + 6'd1;
    end
    if (cmd.h_init) begin
      h_r <= h_sel_val;
    end else if (fin_r) begin
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= h_r[i] + v_r[i];
      end
    end
    case (cmd.save)
      SAVE_MSG:  msg_r  <= h_r;
      SAVE_IPAD: ipad_r <= h_r;
      SAVE_OPAD: opad_r <= h_r;
      SAVE_OUTER: begin
        msg_r <= h_r;
        acc_r <= cmd.acc_first ? h_r : (acc_r ^ h_r);
      end
      default: ;
    endcase
    if (cmd.out_load) begin
      out_r.key_byte  <= dk_rdata;
      out_r.last_byte <= cmd.out_last;
      out_r.overflow  <= cmd.out_ovf;
    end
  end

  assign status.comp_done = fin_r;
  assign out_item = out_r;
endmodule

FILE: rtl/pbk_ctrl.sv
// ----------------------------------------------------------------------------
// PBKDF2 controller
// Sequences loading, message generation, compressions, key storage and output.
// ----------------------------------------------------------------------------
module pbk_ctrl import pbk_pkg::*; #(
  parameter int PASSWORD_MAX = 128,
  parameter int SALT_MAX     = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic [1:0]                      in_cmd,
  output logic                            in_ready,
  input  logic [31:0]                     iter_count,
  input  logic [6:0]                      derived_len,
  input  dp_status_t                      status,
  output ctl_cmd_t                        cmd,
  output logic                            pwd_we,
  output logic [$clog2(PASSWORD_MAX)-1:0] pwd_addr,
  output logic                            salt_we,
  output logic [$clog2(SALT_MAX)-1:0]     salt_addr,
  output logic                            out_valid,
  input  logic                            out_ready
);
  localparam int PCW = $clog2(PASSWORD_MAX + 1);
  localparam int SCW = $clog2(SALT_MAX + 1);
  localparam int PAW = $clog2(PASSWORD_MAX);
  localparam int SAW = $clog2(SALT_MAX);
  localparam int QW  = $clog2(PASSWORD_MAX + SALT_MAX + 3 * BLOCK_BYTES);

  state_t         state_r, state_nxt;
  mode_t          mode_r, mode_nxt;
  logic [QW-1:0]  q_r, q_nxt, msg_n, msg_end, ctr_off;
  logic [PCW-1:0] pw_cnt_r, pw_cnt_nxt;
  logic [SCW-1:0] salt_cnt_r, salt_cnt_nxt;
  logic           ovf_r, ovf_nxt, out_valid_r, out_valid_nxt;
  logic [1:0]     blk_r, blk_nxt, nblk_r, nblk_nxt, nblk_calc;
  logic [31:0]    iters_r, iters_nxt, j_r, j_nxt;
  logic [6:0]     len_r, len_nxt, len_sat;
  logic [5:0]     k_r, k_nxt;
  logic [63:0]    len_bits;
  logic           is_pad, long_pw, out_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pw_cnt_r    <= '0;
      salt_cnt_r  <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pw_cnt_r    <= pw_cnt_nxt;
      salt_cnt_r  <= salt_cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r  <= mode_nxt;
    q_r     <= q_nxt;
    blk_r   <= blk_nxt;
    nblk_r  <= nblk_nxt;
    iters_r <= iters_nxt;
    j_r     <= j_nxt;
    len_r   <= len_nxt;
    k_r     <= k_nxt;
  end

  assign is_pad  = (mode_r == MODE_IPAD) || (mode_r == MODE_OPAD);
  assign long_pw = pw_cnt_r > PCW'(BLOCK_BYTES);
  assign len_sat = (derived_len > 7'(KEY_MAX)) ? 7'(KEY_MAX) : derived_len;
  assign nblk_calc = 2'((8'(len_sat) + 8'(HASH_BYTES - 1)) >> 5);
  assign out_last = ({1'b0, k_r} + 7'd1) == len_r;
  assign ctr_off = q_r - QW'(salt_cnt_r);

  always_comb begin
    case (mode_r)
      MODE_KEYHASH: msg_n = QW'(pw_cnt_r);
      MODE_INNER1:  msg_n = QW'(salt_cnt_r) + QW'(4);
      default:      msg_n = QW'(HASH_BYTES);
    endcase
    if (is_pad) begin
      msg_end = QW'(BLOCK_BYTES);
    end else begin
      msg_end = ((msg_n + QW'(8)) & ~QW'(BLOCK_BYTES - 1)) + QW'(BLOCK_BYTES);
    end
    if (mode_r == MODE_KEYHASH) begin
      len_bits = 64'(msg_n) << 3;
    end else begin
      len_bits = (64'(msg_n) + 64'(BLOCK_BYTES)) << 3;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    q_nxt         = q_r;
    pw_cnt_nxt    = pw_cnt_r;
    salt_cnt_nxt  = salt_cnt_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    blk_nxt       = blk_r;
    nblk_nxt      = nblk_r;
    iters_nxt     = iters_r;
    j_nxt         = j_r;
    len_nxt       = len_r;
    k_nxt         = k_r;
    in_ready      = 1'b0;
    pwd_we        = 1'b0;
    salt_we       = 1'b0;
    pwd_addr      = pw_cnt_r[PAW-1:0];
    salt_addr     = salt_cnt_r[SAW-1:0];
    cmd           = '0;
    cmd.src       = SRC_CONST;
    cmd.h_sel     = HSEL_IV;
    cmd.save      = SAVE_NONE;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_cmd)
            CMD_PASSWORD: begin
              if (pw_cnt_r < PCW'(PASSWORD_MAX)) begin
                pwd_we     = 1'b1;
                pw_cnt_nxt = pw_cnt_r + PCW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            CMD_SALT: begin
              if (salt_cnt_r < SCW'(SALT_MAX)) begin
                salt_we      = 1'b1;
                salt_cnt_nxt = salt_cnt_r + SCW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            CMD_START: begin
              len_nxt   = len_sat;
              nblk_nxt  = nblk_calc;
              iters_nxt = (iter_count == 32'd0) ? 32'd1 : iter_count;
              if (nblk_calc == 2'd0) begin
                pw_cnt_nxt   = '0;
                salt_cnt_nxt = '0;
                ovf_nxt      = 1'b0;
              end else begin
                mode_nxt  = long_pw ? MODE_KEYHASH : MODE_IPAD;
                state_nxt = ST_MSG_INIT;
              end
            end
            default: ;
          endcase
        end
      end

      ST_MSG_INIT: begin
        cmd.h_init = 1'b1;
        case (mode_r)
          MODE_INNER1, MODE_INNERJ: cmd.h_sel = HSEL_IPAD;
          MODE_OUTER:               cmd.h_sel = HSEL_OPAD;
          default:                  cmd.h_sel = HSEL_IV;
        endcase
        q_nxt     = '0;
        state_nxt = ST_FEED;
      end

      ST_FEED: begin
        cmd.byte_vld = 1'b1;
        pwd_addr     = q_r[PAW-1:0];
        salt_addr    = q_r[SAW-1:0];
        if (is_pad) begin
          cmd.xor_byte = (mode_r == MODE_IPAD) ? IPAD_BYTE : OPAD_BYTE;
          if (long_pw) begin
            if (q_r < QW'(HASH_BYTES)) begin
              cmd.src     = SRC_MSG;
              cmd.msg_idx = q_r[4:0];
            end
          end else if (q_r < QW'(pw_cnt_r)) begin
            cmd.src = SRC_PWD;
          end
        end else if (q_r < msg_n) begin
          case (mode_r)
            MODE_KEYHASH: cmd.src = SRC_PWD;
            MODE_INNER1: begin
              if (q_r < QW'(salt_cnt_r)) begin
                cmd.src = SRC_SALT;
              end else if (ctr_off[1:0] == 2'd3) begin
                cmd.const_byte = {6'd0, blk_r};
              end
            end
            default: begin
              cmd.src     = SRC_MSG;
              cmd.msg_idx = q_r[4:0];
            end
          endcase
        end else if (q_r == msg_n) begin
          cmd.const_byte = PAD_MARK;
        end else if (q_r >= msg_end - QW'(8)) begin
          cmd.const_byte = len_bits[{~q_r[2:0], 3'b000} +: 8];
        end
        q_nxt = q_r + QW'(1);
        if (q_r[5:0] == 6'd63) begin
          state_nxt = ST_SETTLE;
        end
      end

      ST_SETTLE: state_nxt = ST_COMP_GO;

      ST_COMP_GO: begin
        cmd.comp_go = 1'b1;
        state_nxt   = ST_COMP_WAIT;
      end

      ST_COMP_WAIT: begin
        if (status.comp_done) begin
          state_nxt = (q_r == msg_end) ? ST_MSG_DONE : ST_FEED;
        end
      end

      ST_MSG_DONE: begin
        state_nxt = ST_MSG_INIT;
        case (mode_r)
          MODE_KEYHASH: begin
            cmd.save = SAVE_MSG;
            mode_nxt = MODE_IPAD;
          end
          MODE_IPAD: begin
            cmd.save = SAVE_IPAD;
            mode_nxt = MODE_OPAD;
          end
          MODE_OPAD: begin
            cmd.save = SAVE_OPAD;
            mode_nxt = MODE_INNER1;
            blk_nxt  = 2'd1;
            j_nxt    = 32'd1;
          end
          MODE_OUTER: begin
            cmd.save      = SAVE_OUTER;
            cmd.acc_first = (j_r == 32'd1);
            if (j_r < iters_r) begin
              j_nxt    = j_r + 32'd1;
              mode_nxt = MODE_INNERJ;
            end else begin
              k_nxt     = '0;
              state_nxt = ST_STORE;
            end
          end
          default: begin
            cmd.save = SAVE_MSG;
            mode_nxt = MODE_OUTER;
          end
        endcase
      end

      ST_STORE: begin
        cmd.dk_we  = 1'b1;
        cmd.dk_idx = {blk_r[1], k_r[4:0]};
        k_nxt      = k_r + 6'd1;
        if (k_r[4:0] == 5'd31) begin
          if (blk_r < nblk_r) begin
            blk_nxt   = blk_r + 2'd1;
            j_nxt     = 32'd1;
            mode_nxt  = MODE_INNER1;
            state_nxt = ST_MSG_INIT;
          end else begin
            k_nxt     = '0;
            state_nxt = ST_OUT_RD;
          end
        end
      end

      ST_OUT_RD: begin
        cmd.dk_idx = k_r;
        state_nxt  = ST_OUT_LD;
      end

      ST_OUT_LD: begin
        cmd.dk_idx    = k_r;
        cmd.out_load  = 1'b1;
        cmd.out_last  = out_last;
        cmd.out_ovf   = ovf_r;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_OUT_HOLD;
      end

      ST_OUT_HOLD: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_last) begin
            pw_cnt_nxt   = '0;
            salt_cnt_nxt = '0;
            ovf_nxt      = 1'b0;
            state_nxt    = ST_IDLE;
          end else begin
            k_nxt     = k_r + 6'd1;
            state_nxt = ST_OUT_RD;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
endmodule

FILE: rtl/pbkdf2_hmac_sha256_engine.sv
// ----------------------------------------------------------------------------
// PBKDF2-HMAC-SHA256 key derivation engine
// Loads password and salt bytes, derives the key and streams it out bytewise.
// ----------------------------------------------------------------------------
// The input stream takes one transaction per cycle while the engine is idle:
// a password byte, a salt byte or a start command. Load transactions produce
// nothing; bytes beyond a store's capacity are dropped and raise the
// overflow mark. A start with a nonzero derived length holds the input
// stream off until the whole key has been delivered.
// Every SHA-256 compression is fed its 64-byte block one byte at a time and
// then runs in the single round unit. A derived block runs every HMAC
// iteration and then stores its 32 bytes, with one more compression when the
// salt exceeds 51 bytes. Keying the pads comes first, and hashing a password
// longer than 64 bytes comes before that. The engine simply holds its output
// register while the receiver stalls.
// The user must write the iteration count and derived length over the APB port
// only while the engine is idle; the block does not enforce this. Reset empties
// both stores, clears the overflow mark and restores the register defaults.
// ----------------------------------------------------------------------------
module pbkdf2_hmac_sha256_engine import pbk_pkg::*; #(
  parameter int PASSWORD_MAX = 128,
  parameter int SALT_MAX     = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  pbk_stream_if.sink         in_stream,
  pbk_stream_if.source       out_stream,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  logic [31:0]                     iter_r;
  logic [6:0]                      dlen_r;
  ctl_cmd_t                        cmd;
  dp_status_t                      status;
  logic                            pwd_we, salt_we;
  logic [$clog2(PASSWORD_MAX)-1:0] pwd_addr;
  logic [$clog2(SALT_MAX)-1:0]     salt_addr;
  in_item_t                        in_item;
  out_item_t                       out_item;

  assign pready  = 1'b1;
  assign in_item = in_stream.data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_r <= ITER_RESET;
      dlen_r <= DLEN_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_DLEN) begin
        dlen_r <= pwdata[6:0];
      end else begin
        iter_r <= pwdata;
      end
    end
  end

  assign prdata = (paddr[2] == REG_DLEN) ? {25'd0, dlen_r} : iter_r;

  pbk_ctrl #(.PASSWORD_MAX(PASSWORD_MAX), .SALT_MAX(SALT_MAX)) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_stream.valid), .in_cmd(in_item.cmd), .in_ready(in_stream.ready),
    .iter_count(iter_r), .derived_len(dlen_r),
    .status(status), .cmd(cmd),
    .pwd_we(pwd_we), .pwd_addr(pwd_addr), .salt_we(salt_we), .salt_addr(salt_addr),
    .out_valid(out_stream.valid), .out_ready(out_stream.ready)
  );

  pbk_datapath #(.PASSWORD_MAX(PASSWORD_MAX), .SALT_MAX(SALT_MAX)) u_datapath (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
    .in_byte(in_item.data_byte),
    .pwd_we(pwd_we), .pwd_addr(pwd_addr), .salt_we(salt_we), .salt_addr(salt_addr),
    .out_item(out_item)
  );

  assign out_stream.data = out_item;
endmodule
